@@ design/sbd_pkg.sv @@
package sbd_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int SINE_STAGES_DEF = 16;
	localparam int ATAN_COUNT = 24;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [29:0] TURN_K = 30'd683565276;
	localparam logic [31:0] CORDIC_X0 = 32'd652032874;
	localparam logic [31:0] ONE_Q30 = 32'd1073741824;

	localparam logic [2:0] REG_LOWER_X = 3'd0;
	localparam logic [2:0] REG_LOWER_Y = 3'd1;
	localparam logic [2:0] REG_LOWER_Z = 3'd2;
	localparam logic [2:0] REG_UPPER_X = 3'd3;
	localparam logic [2:0] REG_UPPER_Y = 3'd4;
	localparam logic [2:0] REG_UPPER_Z = 3'd5;
	localparam logic [2:0] REG_AMP = 3'd6;
	localparam logic [2:0] REG_OMEGA = 3'd7;

	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] t;
		unique case (i)
			0: t = 30'h3243F6A8;
			1: t = 30'h1DAC6705;
			2: t = 30'h0FADBAFC;
			3: t = 30'h07F56EA6;
			4: t = 30'h03FEAB76;
			5: t = 30'h01FFD55B;
			6: t = 30'h00FFFAAA;
			7: t = 30'h007FFF55;
			8: t = 30'h003FFFEA;
			9: t = 30'h001FFFFD;
			10: t = 30'h000FFFFF;
			11: t = 30'h0007FFFF;
			12: t = 30'h0003FFFF;
			13: t = 30'h0001FFFF;
			14: t = 30'h0000FFFF;
			15: t = 30'h00007FFF;
			16: t = 30'h00003FFF;
			17: t = 30'h00001FFF;
			18: t = 30'h00000FFF;
			19: t = 30'h000007FF;
			20: t = 30'h000003FF;
			21: t = 30'h000001FF;
			22: t = 30'h000000FF;
			default: t = 30'h0000007F;
		endcase
		return t;
	endfunction
endpackage

@@ design/sbd_cordic_cell.sv @@
module sbd_cordic_cell import sbd_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] x_in,
	input  logic signed [33:0] y_in,
	input  logic signed [33:0] z_in,
	output logic signed [33:0] x_out,
	output logic signed [33:0] y_out,
	output logic signed [33:0] z_out
);
	logic signed [33:0] atan_v;
	assign atan_v = $signed({4'd0, atan_q30(STAGE)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[33]) begin
				x_out <= x_in - (y_in >>> STAGE);
				y_out <= y_in + (x_in >>> STAGE);
				z_out <= z_in - atan_v;
			end else begin
				x_out <= x_in + (y_in >>> STAGE);
				y_out <= y_in - (x_in >>> STAGE);
				z_out <= z_in + atan_v;
			end
		end
	end
endmodule

@@ design/sbd_sine.sv @@
module sbd_sine import sbd_pkg::*; #(
	parameter int SINE_STAGES = SINE_STAGES_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        turn,
	output logic signed [31:0] sine
);
	localparam int N = (SINE_STAGES < ATAN_COUNT) ? SINE_STAGES : ATAN_COUNT;

	logic [30:0] mag;
	logic [30:0] fold;
	logic [62:0] ang_prod;
	logic [31:0] ang_s1;
	logic neg_s1;
	logic [N-1:0] neg_d;
	logic signed [33:0] xs [0:N];
	logic signed [33:0] ys [0:N];
	logic signed [33:0] zs [0:N];
	logic signed [33:0] yf;

	always_comb begin
		mag = turn[31] ? 31'(-turn) : turn[30:0];
		if (turn == 32'h8000_0000) begin
			mag = 31'h4000_0000;
			mag = 31'd0;
		end
		fold = (mag > 31'h4000_0000) ? (31'h4000_0000 - (mag - 31'h4000_0000)) : mag;
		ang_prod = 63'(fold) * 63'(PI_Q30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_prod[62:31];
			neg_s1 <= turn[31];
		end
	end

	assign xs[0] = $signed({2'd0, CORDIC_X0});
	assign ys[0] = '0;
	assign zs[0] = $signed({2'd0, ang_s1});

	always_ff @(posedge clk) begin
		if (en) neg_d <= {neg_d[N-2:0], neg_s1};
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		sbd_cordic_cell #(.STAGE(i)) u_cell (
			.clk(clk), .en(en),
			.x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
			.x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
		);
	end

	always_comb begin
		yf = ys[N];
		if (yf < 0) yf = '0;
		if (yf > $signed({2'd0, ONE_Q30})) yf = $signed({2'd0, ONE_Q30});
		sine = neg_d[N-1] ? -32'(yf) : 32'(yf);
	end
endmodule

@@ design/sinusoidal_box_displacement.sv @@
// Each accepted vertex passes through one pipeline whose sines use up to 24 CORDIC stages
// (fewer if SINE_STAGES is smaller); its result then waits for the output side.
// Throughput is one vertex per cycle; the whole pipeline holds while the output stalls.
// Reset is asynchronous and active low; it clears the valid flags and the registers
// to their default box, amplitude and frequency.
module sinusoidal_box_displacement import sbd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int SINE_STAGES = SINE_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [47:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] ref_x,
	input  logic signed [COORD_WIDTH-1:0] ref_y,
	input  logic signed [COORD_WIDTH-1:0] ref_z,
	input  logic [15:0]                   elapsed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic signed [COORD_WIDTH-1:0] pos_z
);
	localparam int CW = COORD_WIDTH;
	localparam int N = (SINE_STAGES < ATAN_COUNT) ? SINE_STAGES : ATAN_COUNT;
	localparam int DEPTH = N + 12;
	localparam int DW = CW + 1;

	typedef struct packed {
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic signed [CW-1:0] rz;
	} vert_t;

	logic signed [CW-1:0] lo_q [3];
	logic signed [CW-1:0] hi_q [3];
	logic [47:0] amp_q;
	logic signed [15:0] omega_q;

	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q[0] <= '0; lo_q[1] <= '0; lo_q[2] <= '0;
			hi_q[0] <= CW'(256); hi_q[1] <= CW'(256); hi_q[2] <= '0;
			amp_q <= '0;
			omega_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOWER_X: lo_q[0] <= cfg_data[CW-1:0];
				REG_LOWER_Y: lo_q[1] <= cfg_data[CW-1:0];
				REG_LOWER_Z: lo_q[2] <= cfg_data[CW-1:0];
				REG_UPPER_X: hi_q[0] <= cfg_data[CW-1:0];
				REG_UPPER_Y: hi_q[1] <= cfg_data[CW-1:0];
				REG_UPPER_Z: hi_q[2] <= cfg_data[CW-1:0];
				REG_AMP: amp_q <= cfg_data;
				REG_OMEGA: omega_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in_valid};
	end

	// Vertex delay line.
	vert_t vd [DEPTH];
	always_ff @(posedge clk) begin
		if (en) begin
			vd[0] <= '{ref_x, ref_y, ref_z};
			for (int i = 1; i < DEPTH; i++) vd[i] <= vd[i-1];
		end
	end

	// Time sine: phase and turn fraction over two stages.
	logic signed [31:0] p_s1;
	logic [31:0] turn_s2;
	logic [63:0] tprod;
	assign tprod = 64'(p_s1 * $signed({2'b00, TURN_K}));
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 32'(omega_q * $signed({1'b0, elapsed}));
			turn_s2 <= tprod[47:16];
		end
	end

	// Axis turn fraction needs n*2^31/d; a per-axis restoring divider chain.
	logic signed [CW:0] n_s1 [3];
	logic [CW:0] d_s1 [3];
	logic act_s1 [3];
	logic zero_s1 [3];
	logic [31:0] q_div [3];
	logic signed [31:0] sin_t;
	logic signed [31:0] sin_a [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				n_s1[a] <= $signed({vd[0][(2-a)*CW + CW - 1], vd[0][(2-a)*CW +: CW]})
					- $signed({lo_q[a][CW-1], lo_q[a]});
				d_s1[a] <= unsigned'($signed({hi_q[a][CW-1], hi_q[a]})
					- $signed({lo_q[a][CW-1], lo_q[a]}));
				act_s1[a] <= hi_q[a] > lo_q[a];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			zero_s1[a] = act_s1[a] && (n_s1[a] <= 0 || $unsigned(n_s1[a]) >= d_s1[a]);
		end
	end

	// Divider stage 2: quotient bits of n*2^31/d, unrolled in a registered step per 8 bits.
	localparam int DSTEPS = 4;
	logic [DW:0] rem_p [3][DSTEPS+1];
	logic [31:0] qt_p [3][DSTEPS+1];
	logic [DW-1:0] dv_p [3][DSTEPS+1];
	logic [CW-1:0] nn_p [3];
	always_comb begin
		for (int a = 0; a < 3; a++) nn_p[a] = n_s1[a][CW-1:0];
	end
	// n < d so the integer part is zero; each step yields 8 fraction bits.
	for (genvar a = 0; a < 3; a++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[a][0] <= (DW+1)'(nn_p[a]);
				qt_p[a][0] <= '0;
				dv_p[a][0] <= zero_s1[a] || !act_s1[a] ? DW'(1) : d_s1[a];
			end
		end
		for (genvar s = 0; s < DSTEPS; s++) begin : g_step
			logic [DW:0] r;
			logic [31:0] q;
			always_comb begin
				r = rem_p[a][s];
				q = qt_p[a][s];
				for (int b = 0; b < 8; b++) begin
					r = {r[DW-1:0], 1'b0};
					q = {q[30:0], 1'b0};
					if (r >= (DW+1)'(dv_p[a][s])) begin
						r = r - (DW+1)'(dv_p[a][s]);
						q[0] = 1'b1;
					end
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_p[a][s+1] <= r;
					qt_p[a][s+1] <= q;
					dv_p[a][s+1] <= dv_p[a][s];
				end
			end
		end
		assign q_div[a] = {1'b0, qt_p[a][DSTEPS][31:1]};
	end

	// Flag delay: from stage 1 to the stage where axis sines come out.
	localparam int FD = DSTEPS + 1 + N + 1;
	logic [5:0] flg_d [FD];
	always_ff @(posedge clk) begin
		if (en) begin
			flg_d[0] <= {zero_s1[2], zero_s1[1], zero_s1[0], act_s1[2], act_s1[1], act_s1[0]};
			for (int i = 1; i < FD; i++) flg_d[i] <= flg_d[i-1];
		end
	end

	sbd_sine #(.SINE_STAGES(SINE_STAGES)) u_st (
		.clk(clk), .en(en), .turn(turn_s2), .sine(sin_t)
	);
	for (genvar a = 0; a < 3; a++) begin : g_as
		sbd_sine #(.SINE_STAGES(SINE_STAGES)) u_sa (
			.clk(clk), .en(en), .turn(q_div[a]), .sine(sin_a[a])
		);
	end

	// Time sine is ready before the axis sines, which also pass the divider input register and its DSTEPS steps; delay it.
	logic signed [31:0] st_d [DSTEPS+1];
	always_ff @(posedge clk) begin
		if (en) begin
			st_d[0] <= sin_t;
			for (int i = 1; i < DSTEPS + 1; i++) st_d[i] <= st_d[i-1];
		end
	end

	// Shape product: one axis per stage.
	logic [31:0] sh1, sh2, sh3;
	logic [31:0] sa_y, sa_z;
	logic signed [31:0] st1, st2, st3;
	logic [5:0] f1, f2;
	logic [63:0] m1, m2, m3;
	logic [31:0] g_s;
	logic gneg, gzero;
	assign m1 = 64'(ONE_Q30) * 64'(unsigned'(sin_a[0]));
	always_ff @(posedge clk) begin
		if (en) begin
			sh1 <= flg_d[FD-1][0] ? m1[61:30] : ONE_Q30;
			sa_y <= sin_a[1]; sa_z <= sin_a[2];
			st1 <= st_d[DSTEPS];
			f1 <= flg_d[FD-1];
		end
	end
	assign m2 = 64'(sh1) * 64'(sa_y);
	always_ff @(posedge clk) begin
		if (en) begin
			sh2 <= f1[1] ? m2[61:30] : sh1;
			st2 <= st1; f2 <= f1;
		end
	end
	logic [31:0] sa_z2;
	always_ff @(posedge clk) if (en) sa_z2 <= sa_z;
	assign m3 = 64'(sh2) * 64'(sa_z2);
	always_ff @(posedge clk) begin
		if (en) begin
			sh3 <= f2[2] ? m3[61:30] : sh2;
			st3 <= st2;
			gzero <= |f2[5:3];
		end
	end
	logic [31:0] ms3;
	logic [63:0] mg;
	assign ms3 = st3[31] ? -st3 : st3;
	assign mg = 64'(ms3) * 64'(sh3);
	always_ff @(posedge clk) begin
		if (en) begin
			g_s <= gzero ? 32'd0 : mg[61:30];
			gneg <= st3[31];
		end
	end

	// Displacement and saturation.
	logic signed [CW-1:0] res [3];
	logic [47:0] dprod [3];
	logic [17:0] dmag [3];
	for (genvar a = 0; a < 3; a++) begin : g_disp
		logic signed [15:0] amp;
		logic [15:0] ma;
		logic signed [CW+1:0] sum;
		logic neg;
		assign amp = amp_q[16*a +: 16];
		assign ma = amp[15] ? -amp : amp;
		assign neg = amp[15] != gneg && g_s != 0;
		assign dprod[a] = 48'(ma) * 48'(g_s) + 48'(1 << 29);
		assign dmag[a] = dprod[a][47:30];
		always_comb begin
			sum = (CW+2)'($signed(vd[DEPTH-1][(2-a)*CW +: CW]))
				+ (neg ? -$signed((CW+2)'(dmag[a])) : $signed((CW+2)'(dmag[a])));
			if (CW + 2 <= 18 && dmag[a] >= 18'(1 << CW))
				sum = neg ? -(CW+2)'(1 << CW) : (CW+2)'(1 << CW);
			if (sum > $signed({3'b000, {(CW-1){1'b1}}}))
				res[a] = {1'b0, {(CW-1){1'b1}}};
			else if (sum < $signed({3'b111, {(CW-1){1'b0}}}))
				res[a] = {1'b1, {(CW-1){1'b0}}};
			else
				res[a] = sum[CW-1:0];
		end
	end
	assign pos_x = res[0];
	assign pos_y = res[1];
	assign pos_z = res[2];
endmodule
